>>> design/usbrx_pkg.sv
// Shared types and constants for the USB receive packet ring buffer.
package usbrx_pkg;

   // Default geometry of the ring; the top level hands these down as parameters.
   localparam int BUFFER_BYTES_DEF = 1024;
   localparam int PACKET_BYTES_DEF = 64;

   // Widths fixed by the transfer fields.
   localparam int OP_W   = 2;
   localparam int BYTE_W = 8;
   localparam int FILL_W = 10;

   // Depth of the command queue between the front and the back.
   localparam int CMD_DEPTH   = 2;
   localparam int CMD_PTR_W   = $clog2(CMD_DEPTH);
   localparam int CMD_COUNT_W = $clog2(CMD_DEPTH + 1);

   // Depth of the result queue that drives the rsp_ ports.
   localparam int RSP_DEPTH   = 4;
   localparam int RSP_PTR_W   = $clog2(RSP_DEPTH);
   localparam int RSP_COUNT_W = $clog2(RSP_DEPTH + 1);

   typedef enum logic [OP_W-1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_POLL  = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_DONE    = 2'd0,
      STATUS_EMPTY   = 2'd1,
      STATUS_DROPPED = 2'd2
   } status_type;

   // A classified request as it travels from the front to the back.
   typedef struct packed {
      logic              is_write;
      logic              is_read;
      logic              is_poll;
      logic              is_clear;
      logic [BYTE_W-1:0] data;
      logic              last;
   } cmd_type;

   // One finished result.
   typedef struct packed {
      logic [BYTE_W-1:0] read_byte;
      status_type        status;
      logic              armed;
      logic [FILL_W-1:0] fill;
   } rsp_type;

endpackage

>>> design/usbrx_front.sv
// Front end: accepts requests, decodes the operation and queues the commands.
module usbrx_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [usbrx_pkg::OP_W-1:0]      req_operation,
   input  logic [usbrx_pkg::BYTE_W-1:0]    req_data_byte,
   input  logic                            req_packet_end,
   output logic                            cmd_valid,
   output usbrx_pkg::cmd_type              cmd,
   input  logic                            cmd_pop
);

   localparam int PtrW   = usbrx_pkg::CMD_PTR_W;
   localparam int CountW = usbrx_pkg::CMD_COUNT_W;

   usbrx_pkg::cmd_type queue_ff [usbrx_pkg::CMD_DEPTH];
   logic [PtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CountW-1:0]  count_ff, count_in;
   usbrx_pkg::cmd_type decoded;
   logic               do_push;
   logic               do_pop;

   always_comb begin
      decoded      = '0;
      decoded.data = req_data_byte;
      decoded.last = req_packet_end;
      case (usbrx_pkg::op_type'(req_operation))
         usbrx_pkg::OP_WRITE: decoded.is_write = 1'b1;
         usbrx_pkg::OP_READ:  decoded.is_read  = 1'b1;
         usbrx_pkg::OP_POLL:  decoded.is_poll  = 1'b1;
         usbrx_pkg::OP_CLEAR: decoded.is_clear = 1'b1;
         default:             decoded.is_clear = 1'b0;
      endcase
   end

   assign req_full  = (count_ff == CountW'(usbrx_pkg::CMD_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = queue_ff[rd_ptr_ff];
   assign do_push   = req_push && !req_full;
   assign do_pop    = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PtrW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PtrW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CountW'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - CountW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= decoded;
      end
   end

   // A refused push must leave the fill of the queue alone unless the back pops.
   a_refused_push_holds: assert property (@(posedge clock) disable iff (reset)
      (req_push && req_full && !cmd_pop) |=> $stable(count_ff))
      else $error("command queue changed on a refused push");

endmodule

>>> design/usbrx_back.sv
// Back end: ring state, byte store; executes one command per cycle unless stalled.
module usbrx_back #(
   parameter int BUFFER_BYTES = usbrx_pkg::BUFFER_BYTES_DEF,
   parameter int PACKET_BYTES = usbrx_pkg::PACKET_BYTES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                cmd_valid,
   input  usbrx_pkg::cmd_type                  cmd,
   output logic                                cmd_pop,
   input  logic [usbrx_pkg::RSP_COUNT_W-1:0]   rsp_count,
   output logic                                rsp_push,
   output usbrx_pkg::rsp_type                  rsp_data
);

   localparam int AW         = $clog2(BUFFER_BYTES);
   localparam int OW         = $clog2(PACKET_BYTES + 1);
   localparam int SW         = ((AW > OW) ? AW : OW) + 1;
   localparam int FillW      = usbrx_pkg::FILL_W;
   localparam int CountW     = usbrx_pkg::RSP_COUNT_W;
   localparam int WrapLimit  = BUFFER_BYTES - PACKET_BYTES;
   localparam int SpaceLimit = BUFFER_BYTES - 2 * PACKET_BYTES - 1;

   logic [usbrx_pkg::BYTE_W-1:0] byte_store [BUFFER_BYTES];
   logic [usbrx_pkg::BYTE_W-1:0] rdata_ff;

   logic [AW-1:0]          write_start_ff, write_start_in;
   logic [OW-1:0]          offset_ff, offset_in;
   logic [AW-1:0]          read_pos_ff, read_pos_in;
   logic [AW-1:0]          wrap_point_ff, wrap_point_in;
   logic                   armed_ff, armed_in;
   logic                   res_valid_ff, res_valid_in;
   logic                   res_read_ff, res_read_in;
   usbrx_pkg::status_type  res_status_ff, res_status_in;

   logic [CountW-1:0]      outstanding;
   logic                   exec;
   logic                   mem_we;
   logic                   mem_re;
   logic [SW-1:0]          waddr_wide;
   logic [SW-1:0]          sum_wide;
   logic [AW-1:0]          waddr;
   logic [OW-1:0]          offset_inc;
   logic [AW-1:0]          ws_sum;
   logic                   commit;
   logic                   wrap;
   logic [AW-1:0]          ws_commit;
   logic [AW-1:0]          wp_commit;
   logic [AW-1:0]          fill_now;
   logic [AW-1:0]          fill_commit;
   logic [AW-1:0]          rp_inc;
   logic [AW-1:0]          rp_next;

   // Committed unread bytes; a wrapped difference adds the wrap point, and a
   // result that stays negative counts as an empty buffer.
   function automatic logic [AW-1:0] fill_of(input logic [AW-1:0] ws,
                                             input logic [AW-1:0] rp,
                                             input logic [AW-1:0] wp);
      logic signed [AW+1:0] len;
      len = $signed({2'b00, ws}) - $signed({2'b00, rp});
      if (len < 0) begin
         len = len + $signed({2'b00, wp});
      end
      if (len < 0) begin
         len = '0;
      end
      return len[AW-1:0];
   endfunction

   // Receive may stay armed only while space left exceeds 2 * PACKET_BYTES + 1.
   function automatic logic space_ok(input logic [AW-1:0] fill);
      return int'(fill) < SpaceLimit;
   endfunction

   // Results in flight count against the result queue so a push never overflows it.
   assign outstanding = rsp_count + CountW'(res_valid_ff);
   assign exec        = cmd_valid && (outstanding < CountW'(usbrx_pkg::RSP_DEPTH));
   assign cmd_pop     = exec;

   assign fill_now    = fill_of(write_start_ff, read_pos_ff, wrap_point_ff);
   assign offset_inc  = offset_ff + OW'(1);
   assign waddr_wide  = SW'(write_start_ff) + SW'(offset_ff);
   assign waddr       = waddr_wide[AW-1:0];
   assign sum_wide    = SW'(write_start_ff) + SW'(offset_inc);
   assign ws_sum      = sum_wide[AW-1:0];
   assign commit      = cmd.last || (int'(offset_inc) >= PACKET_BYTES);
   assign wrap        = int'(ws_sum) >= WrapLimit;
   assign ws_commit   = wrap ? '0 : ws_sum;
   assign wp_commit   = wrap ? ws_sum : wrap_point_ff;
   assign fill_commit = fill_of(ws_commit, read_pos_ff, wp_commit);
   assign rp_inc      = read_pos_ff + AW'(1);
   assign rp_next     = (rp_inc == wrap_point_ff) ? '0 : rp_inc;

   always_comb begin
      write_start_in = write_start_ff;
      offset_in      = offset_ff;
      read_pos_in    = read_pos_ff;
      wrap_point_in  = wrap_point_ff;
      armed_in       = armed_ff;
      res_valid_in   = exec;
      res_read_in    = 1'b0;
      res_status_in  = usbrx_pkg::STATUS_DONE;
      mem_we         = 1'b0;
      mem_re         = 1'b0;
      if (exec) begin
         if (cmd.is_write) begin
            if (!armed_ff) begin
               res_status_in = usbrx_pkg::STATUS_DROPPED;
            end else begin
               mem_we = 1'b1;
               if (commit) begin
                  write_start_in = ws_commit;
                  wrap_point_in  = wp_commit;
                  offset_in      = '0;
                  armed_in       = space_ok(fill_commit);
               end else begin
                  offset_in = offset_inc;
               end
            end
         end else if (cmd.is_read) begin
            if (fill_now == '0) begin
               res_status_in = usbrx_pkg::STATUS_EMPTY;
            end else begin
               res_read_in = 1'b1;
               mem_re      = 1'b1;
               read_pos_in = rp_next;
            end
         end else if (cmd.is_poll) begin
            if (!armed_ff && space_ok(fill_now)) begin
               armed_in = 1'b1;
            end
         end else if (cmd.is_clear) begin
            read_pos_in = write_start_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_start_ff <= '0;
         offset_ff      <= '0;
         read_pos_ff    <= '0;
         wrap_point_ff  <= '0;
         armed_ff       <= 1'b1;
         res_valid_ff   <= 1'b0;
         res_read_ff    <= 1'b0;
         res_status_ff  <= usbrx_pkg::STATUS_DONE;
      end else begin
         write_start_ff <= write_start_in;
         offset_ff      <= offset_in;
         read_pos_ff    <= read_pos_in;
         wrap_point_ff  <= wrap_point_in;
         armed_ff       <= armed_in;
         res_valid_ff   <= res_valid_in;
         res_read_ff    <= res_read_in;
         res_status_ff  <= res_status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         byte_store[waddr] <= cmd.data;
      end
      if (mem_re) begin
         rdata_ff <= byte_store[read_pos_ff];
      end
   end

   // The registers now hold the state left by the previous command, which is
   // what its result reports.
   assign rsp_push           = res_valid_ff;
   assign rsp_data.read_byte = res_read_ff ? rdata_ff : '0;
   assign rsp_data.status    = res_status_ff;
   assign rsp_data.armed     = armed_ff;
   assign rsp_data.fill      = FillW'(fill_now);

   a_exec_gives_result: assert property (@(posedge clock) disable iff (reset)
      exec |=> rsp_push)
      else $error("executed command produced no result");

   a_offset_below_packet: assert property (@(posedge clock) disable iff (reset)
      int'(offset_ff) < PACKET_BYTES)
      else $error("packet offset reached a full packet without commit");

   a_drop_when_disarmed: assert property (@(posedge clock) disable iff (reset)
      (exec && cmd.is_write && !armed_ff) |=>
         (rsp_data.status == usbrx_pkg::STATUS_DROPPED) && $stable(write_start_ff))
      else $error("disarmed write was not dropped");

endmodule

>>> design/usbrx_rsp_fifo.sv
// Result queue that presents the oldest finished result on the rsp_ ports.
module usbrx_rsp_fifo (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   input  usbrx_pkg::rsp_type                  push_data,
   input  logic                                pop,
   output logic                                empty,
   output usbrx_pkg::rsp_type                  head,
   output logic [usbrx_pkg::RSP_COUNT_W-1:0]   count
);

   localparam int PtrW   = usbrx_pkg::RSP_PTR_W;
   localparam int CountW = usbrx_pkg::RSP_COUNT_W;

   usbrx_pkg::rsp_type entries_ff [usbrx_pkg::RSP_DEPTH];
   logic [PtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CountW-1:0]  count_ff, count_in;
   logic               do_pop;

   assign empty  = (count_ff == '0);
   assign head   = entries_ff[rd_ptr_ff];
   assign count  = count_ff;
   assign do_pop = pop && !empty;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PtrW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PtrW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + CountW'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - CountW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   // The back end reserves a slot before it executes, so a push never meets a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < CountW'(usbrx_pkg::RSP_DEPTH)))
      else $error("result pushed into a full queue");

endmodule

>>> design/usb_rx_packet_ring_buffer.sv
// Top level of the USB receive packet ring buffer.
//
//   Channel   Ports                                              Handshake
//   request   req_operation, req_data_byte, req_packet_end       req_push / req_full
//   result    rsp_read_byte, rsp_status, rsp_receive_armed,      rsp_pop / rsp_empty
//             rsp_fill_level
//
// Each request transfer yields exactly one result transfer, in order.
// The block sustains one request per cycle while req_full is low. A request waits
// in the command queue until the back end executes it, once the result queue has
// room; the result, whose byte store read is registered, is held in the back end's
// result registers and then pushed into the result queue. The single-port byte
// store and the ring pointers handle one command per cycle. Reset is synchronous
// and leaves the ring empty with receive armed; the byte store itself is not
// cleared. When results are not popped, the result queue fills, the back end stops
// taking commands, and req_full rises once the two-entry command queue is full.
module usb_rx_packet_ring_buffer #(
   parameter int BUFFER_BYTES = usbrx_pkg::BUFFER_BYTES_DEF,
   parameter int PACKET_BYTES = usbrx_pkg::PACKET_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [usbrx_pkg::OP_W-1:0]      req_operation,
   input  logic [usbrx_pkg::BYTE_W-1:0]    req_data_byte,
   input  logic                            req_packet_end,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [usbrx_pkg::BYTE_W-1:0]    rsp_read_byte,
   output logic [1:0]                      rsp_status,
   output logic                            rsp_receive_armed,
   output logic [usbrx_pkg::FILL_W-1:0]    rsp_fill_level
);

   // Commands from the front end to the back end.
   logic                                 cmd_valid;
   usbrx_pkg::cmd_type                   cmd;
   logic                                 cmd_pop;

   // Results from the back end into the result queue.
   logic                                 rsp_push;
   usbrx_pkg::rsp_type                   rsp_data;
   usbrx_pkg::rsp_type                   rsp_head;
   logic [usbrx_pkg::RSP_COUNT_W-1:0]    rsp_count;

   // The front end decodes each request and buffers it, so requests are still taken
   // while the back end waits for room, until the command queue is full.
   usbrx_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_operation  (req_operation),
      .req_data_byte  (req_data_byte),
      .req_packet_end (req_packet_end),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .cmd_pop        (cmd_pop)
   );

   // The back end owns the ring pointers, the armed flag and the byte store.
   usbrx_back #(
      .BUFFER_BYTES (BUFFER_BYTES),
      .PACKET_BYTES (PACKET_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_count (rsp_count),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_data)
   );

   // Finished results wait here until the consumer pops them.
   usbrx_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_data),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .head      (rsp_head),
      .count     (rsp_count)
   );

   assign rsp_read_byte     = rsp_head.read_byte;
   assign rsp_status        = rsp_head.status;
   assign rsp_receive_armed = rsp_head.armed;
   assign rsp_fill_level    = rsp_head.fill;

endmodule

>>> sim/usb_rx_packet_ring_buffer_checker.sv
`timescale 1ns / 1ps
// Checker that predicts every receive ring buffer result and compares it with the block's output.
module usb_rx_packet_ring_buffer_checker
   import usbrx_pkg::*;
#(
   parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
   parameter int PACKET_BYTES = PACKET_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  logic              req_full,
   input  logic [OP_W-1:0]   req_operation,
   input  logic [BYTE_W-1:0] req_data_byte,
   input  logic              req_packet_end,
   input  logic              rsp_empty,
   input  logic              rsp_pop,
   input  logic [BYTE_W-1:0] rsp_read_byte,
   input  logic [1:0]        rsp_status,
   input  logic              rsp_receive_armed,
   input  logic [FILL_W-1:0] rsp_fill_level,
   input  logic              finish_check,
   output int                pending,
   output int                fail_count,
   // Bit 33: receive armed, bit 32: a read now would touch a never written byte,
   // bits 31:0: number of request transfers taken so far.
   output logic [33:0]       intake_state
);

   logic [BYTE_W-1:0] ring_mem [BUFFER_BYTES];
   bit                ring_written [BUFFER_BYTES];
   int                base_ptr;
   int                frag_len;
   int                tail_ptr;
   int                wrap_mark;
   bit                rx_armed;
   int unsigned       accepted_total;
   rsp_type           predicted_results [$];

   task automatic report_mismatch(input string what);
      $display("[%0t] ring buffer check: %s", $time, what);
      fail_count++;
   endtask

   function automatic int held_bytes();
      int span;
      span = base_ptr - tail_ptr;
      if (span < 0) span += wrap_mark;
      if (span < 0) span = 0;
      return span;
   endfunction

   function automatic bit room_for_packet();
      return (BUFFER_BYTES - PACKET_BYTES - 1 - held_bytes()) > PACKET_BYTES;
   endfunction

   task automatic apply_request(input op_type op, input logic [BYTE_W-1:0] data,
                                input logic last, output rsp_type r);
      int slot;
      r = '0;
      r.status = STATUS_DONE;
      case (op)
         OP_WRITE: begin
            if (!rx_armed) begin
               r.status = STATUS_DROPPED;
            end else begin
               slot = (base_ptr + frag_len) % BUFFER_BYTES;
               ring_mem[slot] = data;
               ring_written[slot] = 1'b1;
               frag_len++;
               if (last || frag_len >= PACKET_BYTES) begin
                  base_ptr = (base_ptr + frag_len) % BUFFER_BYTES;
                  frag_len = 0;
                  if (base_ptr >= BUFFER_BYTES - PACKET_BYTES) begin
                     wrap_mark = base_ptr;
                     base_ptr = 0;
                  end
                  rx_armed = room_for_packet();
               end
            end
         end
         OP_READ: begin
            if (held_bytes() == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               r.read_byte = ring_mem[tail_ptr];
               tail_ptr = (tail_ptr + 1) % BUFFER_BYTES;
               if (tail_ptr == wrap_mark) tail_ptr = 0;
            end
         end
         OP_POLL: begin
            if (!rx_armed && room_for_packet()) rx_armed = 1'b1;
         end
         default: begin
            tail_ptr = base_ptr;
         end
      endcase
      r.armed = rx_armed;
      r.fill = FILL_W'(held_bytes());
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         foreach (ring_written[i]) ring_written[i] = 1'b0;
         base_ptr = 0;
         frag_len = 0;
         tail_ptr = 0;
         wrap_mark = 0;
         rx_armed = 1'b1;
         accepted_total = 0;
         predicted_results.delete();
         fail_count = 0;
         pending <= 0;
         intake_state <= {1'b1, 1'b0, 32'd0};
      end else begin
         // Results are matched before new requests are queued, so a stray result
         // can never pair with a request taken at the same edge.
         if (rsp_pop && !rsp_empty) begin
            if (predicted_results.size() == 0) begin
               report_mismatch("result transfer with no request outstanding");
            end else begin
               want = predicted_results.pop_front();
               if (rsp_read_byte !== want.read_byte)
                  report_mismatch($sformatf("read_byte %h, expected %h",
                                            rsp_read_byte, want.read_byte));
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_status, want.status));
               if (rsp_receive_armed !== want.armed)
                  report_mismatch($sformatf("receive_armed %b, expected %b",
                                            rsp_receive_armed, want.armed));
               if (rsp_fill_level !== want.fill)
                  report_mismatch($sformatf("fill_level %0d, expected %0d",
                                            rsp_fill_level, want.fill));
            end
         end
         if (req_push && !req_full) begin
            apply_request(op_type'(req_operation), req_data_byte, req_packet_end, want);
            predicted_results.push_back(want);
            accepted_total++;
            intake_state <= {rx_armed, held_bytes() > 0 && !ring_written[tail_ptr],
                             accepted_total};
         end
         if (finish_check && predicted_results.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived",
                                      predicted_results.size()));
            predicted_results.delete();
         end
         pending <= predicted_results.size();
      end
   end

endmodule

>>> sim/usb_rx_packet_ring_buffer_tb.sv
`timescale 1ns / 1ps
// Testbench top for the USB receive packet ring buffer: stimulus, result consumer and verdict.
module usb_rx_packet_ring_buffer_tb;
   import usbrx_pkg::*;

   localparam int RING_BYTES    = BUFFER_BYTES_DEF;
   localparam int PKT_BYTES     = PACKET_BYTES_DEF;
   // Random request transfers after the directed opening.
   localparam int RANDOM_ITEMS  = 1300;
   // Cycles to wait once nothing is outstanding, to catch any result that should
   // not exist.
   localparam int SETTLE_CYCLES = 12;
   // The slowest correct run is roughly 1350 transfers, each with a drawn idle gap
   // on both sides plus the pipeline. Allow far more.
   localparam int CYCLE_LIMIT   = 500000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_push = 1'b0;
   logic              req_full;
   logic [OP_W-1:0]   req_operation = OP_POLL;
   logic [BYTE_W-1:0] req_data_byte = '0;
   logic              req_packet_end = 1'b0;
   logic              rsp_empty;
   logic              rsp_pop = 1'b0;
   logic [BYTE_W-1:0] rsp_read_byte;
   logic [1:0]        rsp_status;
   logic              rsp_receive_armed;
   logic [FILL_W-1:0] rsp_fill_level;
   logic              finish_check = 1'b0;
   int                pending;
   int                fail_count;
   logic [33:0]       intake_state;

   int unsigned       sent_count = 0;
   int unsigned       popped_count = 0;
   int unsigned       cycle_count = 0;
   bit                producer_calm = 1'b0;
   bit                consumer_calm = 1'b0;

   always #5 clock = ~clock;

   usb_rx_packet_ring_buffer #(
      .BUFFER_BYTES(RING_BYTES),
      .PACKET_BYTES(PKT_BYTES)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_operation    (req_operation),
      .req_data_byte    (req_data_byte),
      .req_packet_end   (req_packet_end),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_read_byte    (rsp_read_byte),
      .rsp_status       (rsp_status),
      .rsp_receive_armed(rsp_receive_armed),
      .rsp_fill_level   (rsp_fill_level)
   );

   usb_rx_packet_ring_buffer_checker #(
      .BUFFER_BYTES(RING_BYTES),
      .PACKET_BYTES(PKT_BYTES)
   ) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_operation    (req_operation),
      .req_data_byte    (req_data_byte),
      .req_packet_end   (req_packet_end),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_read_byte    (rsp_read_byte),
      .rsp_status       (rsp_status),
      .rsp_receive_armed(rsp_receive_armed),
      .rsp_fill_level   (rsp_fill_level),
      .finish_check     (finish_check),
      .pending          (pending),
      .fail_count       (fail_count),
      .intake_state     (intake_state)
   );

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("usb_rx_packet_ring_buffer regression: fail");
         $finish;
      end
   end

   // Presents one request and returns in the time step of its transfer, after the
   // checker has folded it into its prediction. The push line is written at most
   // once per time step: it is dropped only when an idle gap follows, and a
   // back-to-back request simply keeps it high.
   task automatic offer(input op_type op, input logic [BYTE_W-1:0] data, input logic last);
      int unsigned gap;
      // A read whose target byte was never written lies outside the contract, so
      // such a read is turned into a harmless poll.
      if (op == OP_READ && intake_state[32]) op = OP_POLL;
      if (sent_count % 48 == 0) producer_calm = ($urandom_range(0, 3) == 0);
      gap = producer_calm ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
         if (req_push) req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push       <= 1'b1;
      req_operation  <= op;
      req_data_byte  <= data;
      req_packet_end <= last;
      do @(posedge clock); while (req_full);
      sent_count++;
      // The checker updates its view in the same time step; wait for it so the
      // next choice sees the state after this transfer.
      wait (intake_state[31:0] == sent_count);
   endtask

   // One received packet. Most end with the marker on their last byte; some run
   // past the packet size so the block must commit on its own at the size limit;
   // a few stop without a marker and merge into whatever is written next.
   task automatic send_packet();
      int unsigned len;
      int unsigned kind;
      bit          mark_end;
      kind = $urandom_range(0, 19);
      if (kind < 16) begin
         len = $urandom_range(1, PKT_BYTES);
         mark_end = 1'b1;
      end else if (kind < 19) begin
         len = $urandom_range(PKT_BYTES + 1, 2 * PKT_BYTES + 2);
         mark_end = 1'b1;
      end else begin
         len = $urandom_range(1, 10);
         mark_end = 1'b0;
      end
      for (int unsigned i = 1; i <= len; i++) begin
         offer(OP_WRITE, BYTE_W'($urandom), mark_end && i == len);
      end
   endtask

   // Reads carry random values in the ignored fields so every input bit toggles.
   task automatic read_burst(input int unsigned count);
      repeat (count) offer(OP_READ, BYTE_W'($urandom), 1'($urandom));
   endtask

   // Result consumer: waits a drawn number of cycles before each pop, with
   // occasional stretches where it pops every cycle.
   initial begin
      int unsigned gap;
      wait (!reset);
      forever begin
         if (popped_count % 56 == 0) consumer_calm = ($urandom_range(0, 3) == 0);
         gap = consumer_calm ? 0 : $urandom_range(0, 19);
         if (gap != 0) begin
            if (rsp_pop) rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         popped_count++;
      end
   end

   initial begin
      int unsigned pick;
      int unsigned random_goal;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed opening. A read with nothing stored, then a poll while armed.
      offer(OP_READ, 8'hFF, 1'b1);
      offer(OP_POLL, 8'h00, 1'b0);
      // A two-byte packet with the extreme byte values, read back, then one read
      // too many.
      offer(OP_WRITE, 8'h00, 1'b0);
      offer(OP_WRITE, 8'hFF, 1'b1);
      offer(OP_READ, 8'h00, 1'b0);
      offer(OP_READ, 8'h00, 1'b0);
      offer(OP_READ, 8'hAA, 1'b1);
      // An open packet is not counted as stored, and a clear leaves it in place so
      // the byte after the clear completes it.
      offer(OP_WRITE, 8'hA5, 1'b0);
      offer(OP_READ, 8'h3C, 1'b0);
      offer(OP_CLEAR, 8'h55, 1'b1);
      offer(OP_WRITE, 8'h5A, 1'b1);
      offer(OP_READ, 8'h00, 1'b0);
      offer(OP_READ, 8'h00, 1'b0);
      // A clear throws away committed bytes that were only partly read.
      offer(OP_WRITE, 8'h01, 1'b0);
      offer(OP_WRITE, 8'h80, 1'b0);
      offer(OP_WRITE, 8'h7F, 1'b1);
      offer(OP_READ, 8'h00, 1'b0);
      offer(OP_CLEAR, 8'h00, 1'b0);
      offer(OP_READ, 8'h00, 1'b0);
      // Clear and poll on an empty ring.
      offer(OP_CLEAR, 8'hFF, 1'b0);
      offer(OP_POLL, 8'hFF, 1'b1);

      // Random part. While receive is armed, writes dominate so the ring fills,
      // wraps and eventually disarms; once disarmed, reads drain it, polls re-arm
      // it, and stray writes check that dropped bytes leave everything alone.
      random_goal = sent_count + RANDOM_ITEMS;
      while (sent_count < random_goal) begin
         pick = $urandom_range(0, 99);
         if (intake_state[33]) begin
            if (pick < 78) send_packet();
            else if (pick < 88) read_burst($urandom_range(1, 4));
            else if (pick < 90) read_burst($urandom_range(20, 90));
            else if (pick < 95) offer(OP_POLL, BYTE_W'($urandom), 1'($urandom));
            else offer(op_type'($urandom_range(0, 3)), BYTE_W'($urandom), 1'($urandom));
         end else begin
            if (pick < 45) begin
               read_burst($urandom_range(5, 40));
            end else if (pick < 75) begin
               offer(OP_POLL, BYTE_W'($urandom), 1'($urandom));
            end else if (pick < 95) begin
               repeat ($urandom_range(1, 4))
                  offer(OP_WRITE, BYTE_W'($urandom), 1'($urandom));
            end else begin
               offer(OP_CLEAR, BYTE_W'($urandom), 1'($urandom));
            end
         end
      end

      // Stimulus done: let every result drain, then give stray results a chance to
      // show up before asking the checker for anything still outstanding.
      req_push <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      finish_check <= 1'b1;
      repeat (2) @(posedge clock);
      if (fail_count == 0) begin
         $display("usb_rx_packet_ring_buffer regression: pass");
      end else begin
         $display("usb_rx_packet_ring_buffer regression: fail");
      end
      $finish;
   end

endmodule
